### rtl/abrf_pkg.sv
// shared types, constants and codes for the alpha blended rectangle fill block
`timescale 1ns / 1ps

package abrf_pkg;

	localparam int FB_PIXELS_DEF = 4096;
	localparam int MAX_DIM_DEF   = 64;

	localparam int PIX_W    = 32;
	localparam int POS_W    = 6;
	localparam int DIM_W    = 7;
	localparam int STRIDE_W = 7;
	// coordinate after adding a rectangle offset: up to 63 + 63
	localparam int COORD_W  = 8;
	// computed address before range check: up to 126 * 127 + 126
	localparam int CALC_W   = 16;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 7'd64;

	typedef enum logic [1:0] {
		CMD_FILL  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_READ_WAIT,
		ST_MULT,
		ST_STORE,
		ST_FINISH
	} state_e;

	typedef struct packed {
		logic [1:0]       command;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
		logic [PIX_W-1:0] color;
	} cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] read_value;
		logic             out_of_range;
	} res_t;

	typedef struct packed {
		logic [CALC_W-1:0] addr;
		logic              in_range;
	} addr_res_t;

endpackage

### rtl/alpha_blend_rect_fill.sv
// top level: framebuffer with blended rectangle fill, pixel write and pixel read
//
// usage
// - an item is a command on cmd, taken at a rising edge with start high and busy low
// - fill blends every in-range pixel of the rectangle with the item color, per byte,
//   weighted by the color alpha byte; write stores one pixel, read returns one
// - each item gives exactly one result on result, shown for one cycle with
//   done high; the receiver cannot stall, so the result is never held
// - row_stride is written with row_stride_we / row_stride_wdata while idle; the user
//   must keep to this, the block itself does not enforce it
// - read waits for the registered ram output unless the pixel is beyond the store
// - fill takes each pixel in range through ram read, blend multiply and write back,
//   one pixel at a time on the single ram port pair and shared blend unit; a pixel
//   beyond the store is skipped
// - the next item is taken in the cycle after done
// reset
// - sequencer returns to idle, row stride goes to 64; pixel contents are
//   undefined until written and are not cleared
`timescale 1ns / 1ps

module alpha_blend_rect_fill import abrf_pkg::*; #(
	parameter int FB_PIXELS = FB_PIXELS_DEF,
	parameter int MAX_DIM   = MAX_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cmd_t                cmd,
	output logic                done,
	output res_t                result,
	input  logic                row_stride_we,
	input  logic [STRIDE_W-1:0] row_stride_wdata
);

	localparam int AW = $clog2(FB_PIXELS);

	state_e state_q, state_d;

	// configuration
	logic [STRIDE_W-1:0] stride_q;

	// latched item and walk counters
	cmd_t             cmd_q;
	logic [DIM_W-1:0] w_q, h_q;
	logic [DIM_W-1:0] r_q, c_q;
	logic [AW-1:0]    addr_q;
	logic [PIX_W-1:0] rd_q;
	logic             oor_q;

	// saturated rectangle size of the incoming item
	logic [DIM_W-1:0] w_sat, h_sat;

	// sequencer controls
	logic accept;
	logic pix_adv;
	logic oor_set;
	logic blend_load;
	logic rd_cap;
	logic we_access;
	logic we_store;
	logic last_pix;

	// shared units
	logic [COORD_W-1:0] cur_row, cur_col;
	addr_res_t          ar;
	logic [AW-1:0]      ram_waddr;
	logic [PIX_W-1:0]   ram_wdata;
	logic [PIX_W-1:0]   ram_rdata;
	logic [PIX_W-1:0]   blended;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign w_sat = (32'(cmd.rect_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cmd.rect_width;
	assign h_sat = (32'(cmd.rect_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cmd.rect_height;

	// current pixel: origin plus walk offsets, no clipping against the stride
	assign cur_row  = COORD_W'(cmd_q.pos_y) + COORD_W'(r_q);
	assign cur_col  = COORD_W'(cmd_q.pos_x) + COORD_W'(c_q);
	assign last_pix = (c_q == w_q - 7'd1) && (r_q == h_q - 7'd1);

	abrf_addr #(
		.FB_PIXELS(FB_PIXELS)
	) u_addr (
		.row   (cur_row),
		.col   (cur_col),
		.stride(stride_q),
		.res   (ar)
	);

	// write back uses the latched address, a pixel write the live one
	assign ram_waddr = (state_q == ST_STORE) ? addr_q : AW'(ar.addr);
	assign ram_wdata = (state_q == ST_STORE) ? blended : cmd_q.color;

	abrf_ram #(
		.WIDTH(PIX_W),
		.DEPTH(FB_PIXELS)
	) u_ram (
		.clk  (clk),
		.we   (we_access || we_store),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(AW'(ar.addr)),
		.rdata(ram_rdata)
	);

	abrf_blend u_blend (
		.clk    (clk),
		.load   (blend_load),
		.old_pix(ram_rdata),
		.color  (cmd_q.color),
		.blended(blended)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d    = state_q;
		pix_adv    = 1'b0;
		oor_set    = 1'b0;
		blend_load = 1'b0;
		rd_cap     = 1'b0;
		we_access  = 1'b0;
		we_store   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd_e'(cmd.command))
						CMD_FILL: begin
							state_d = (w_sat == '0 || h_sat == '0) ? ST_FINISH : ST_ACCESS;
						end
						CMD_WRITE: state_d = ST_ACCESS;
						CMD_READ:  state_d = ST_ACCESS;
						default:   state_d = ST_FINISH;
					endcase
				end
			end
			ST_ACCESS: begin
				case (cmd_e'(cmd_q.command))
					CMD_FILL: begin
						if (ar.in_range) begin
							state_d = ST_MULT;
						end else begin
							// skipped pixel, the rest of the rectangle goes on
							oor_set = 1'b1;
							pix_adv = 1'b1;
							state_d = last_pix ? ST_FINISH : ST_ACCESS;
						end
					end
					CMD_WRITE: begin
						we_access = ar.in_range;
						oor_set   = !ar.in_range;
						state_d   = ST_FINISH;
					end
					CMD_READ: begin
						oor_set = !ar.in_range;
						state_d = ar.in_range ? ST_READ_WAIT : ST_FINISH;
					end
					default: state_d = ST_FINISH;
				endcase
			end
			ST_READ_WAIT: begin
				rd_cap  = 1'b1;
				state_d = ST_FINISH;
			end
			ST_MULT: begin
				blend_load = 1'b1;
				state_d    = ST_STORE;
			end
			ST_STORE: begin
				we_store = 1'b1;
				pix_adv  = 1'b1;
				state_d  = last_pix ? ST_FINISH : ST_ACCESS;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
			r_q      <= '0;
			c_q      <= '0;
			oor_q    <= 1'b0;
		end else begin
			if (row_stride_we) begin
				stride_q <= row_stride_wdata;
			end
			if (accept) begin
				r_q   <= '0;
				c_q   <= '0;
				oor_q <= 1'b0;
			end else begin
				if (oor_set) begin
					oor_q <= 1'b1;
				end
				// raster walk: columns first, then next row
				if (pix_adv) begin
					if (c_q == w_q - 7'd1) begin
						c_q <= '0;
						r_q <= r_q + 7'd1;
					end else begin
						c_q <= c_q + 7'd1;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			w_q   <= w_sat;
			h_q   <= h_sat;
			rd_q  <= '0;
		end else if (rd_cap) begin
			rd_q <= ram_rdata;
		end
		if (state_q == ST_ACCESS) begin
			addr_q <= AW'(ar.addr);
		end
	end

	assign done                = (state_q == ST_FINISH);
	assign result.read_value   = rd_q;
	assign result.out_of_range = oor_q;

endmodule

### rtl/abrf_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module abrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/abrf_addr.sv
// pixel address unit: row times stride plus column, checked against store size
`timescale 1ns / 1ps

module abrf_addr import abrf_pkg::*; #(
	parameter int FB_PIXELS = FB_PIXELS_DEF
) (
	input  logic [COORD_W-1:0]  row,
	input  logic [COORD_W-1:0]  col,
	input  logic [STRIDE_W-1:0] stride,
	output addr_res_t           res
);

	logic [COORD_W+STRIDE_W-1:0] prod;
	logic [CALC_W-1:0]           sum;

	always_comb begin
		prod         = row * stride;
		sum          = CALC_W'(prod) + CALC_W'(col);
		res.addr     = sum;
		res.in_range = (32'(sum) < 32'(FB_PIXELS));
	end

endmodule

### rtl/abrf_blend.sv
// per byte blend unit: registered multiply-add, then exact divide by 255
`timescale 1ns / 1ps

module abrf_blend import abrf_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic [PIX_W-1:0] old_pix,
	input  logic [PIX_W-1:0] color,
	output logic [PIX_W-1:0] blended
);

	logic [7:0]  alpha;
	logic [7:0]  inv_alpha;
	logic [15:0] sum_d  [4];
	logic [15:0] sum_s1 [4];
	logic [16:0] quot   [4];

	always_comb begin
		alpha     = color[31:24];
		inv_alpha = 8'd255 - alpha;
		for (int k = 0; k < 4; k++) begin
			sum_d[k] = ({8'd0, old_pix[8*k +: 8]} * {8'd0, inv_alpha})
				+ ({8'd0, color[8*k +: 8]} * {8'd0, alpha});
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < 4; k++) begin
				sum_s1[k] <= sum_d[k];
			end
		end
	end

	// floor(s / 255) = (s + 1 + (s >> 8)) >> 8, exact for s up to 255 * 255
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			quot[k] = {1'b0, sum_s1[k]} + 17'd1 + {9'd0, sum_s1[k][15:8]};
			blended[8*k +: 8] = quot[k][15:8];
		end
	end

endmodule

### bench/testbench.sv
// self-checking testbench for the alpha blended rectangle fill block
`timescale 1ns / 1ps

module testbench;
	import abrf_pkg::*;

	// the limit covers a full 64 by 64 in-range fill plus the longest sender gap
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int N_PHASE_ITEMS  = 5;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	cmd_t                cmd = '0;
	logic                done;
	res_t                result;
	logic                row_stride_we = 1'b0;
	logic [STRIDE_W-1:0] row_stride_wdata = '0;

	// items waiting to be driven, results waiting to come back
	cmd_t pending_cmds[$];
	res_t expected_results[$];

	// shadow of the block: pixel store and row stride as the block sees them
	logic [PIX_W-1:0] fb_model [FB_PIXELS_DEF];
	int               model_stride = int'(STRIDE_RESET);

	// generator side: which addresses have been written, and the stride in force
	bit gen_written [FB_PIXELS_DEF];
	int gen_stride = int'(STRIDE_RESET);

	int gap_left = 0;
	int burst_left = 0;
	int quiet_cycles = 0;
	int err_count = 0;

	alpha_blend_rect_fill u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.cmd              (cmd),
		.done             (done),
		.result           (result),
		.row_stride_we    (row_stride_we),
		.row_stride_wdata (row_stride_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// linear pixel address; anything at FB_PIXELS_DEF or above lies beyond the store
	function automatic int pix_addr(int x, int y, int stride);
		return y * stride + x;
	endfunction

	// per-byte blend, alpha byte included: floor((old*(255-a) + col*a) / 255)
	function automatic logic [PIX_W-1:0] blend_px(logic [PIX_W-1:0] old_px,
			logic [PIX_W-1:0] col);
		int               alpha;
		int               ob;
		int               cb;
		logic [PIX_W-1:0] blended;
		alpha = int'(col[31:24]);
		for (int k = 0; k < 4; k++) begin
			ob = int'(old_px[8*k +: 8]);
			cb = int'(col[8*k +: 8]);
			blended[8*k +: 8] = 8'((ob * (255 - alpha) + cb * alpha) / 255);
		end
		return blended;
	endfunction

	// run one command on the shadow store and return the result it must give
	function automatic res_t apply_command(cmd_t c);
		res_t r;
		int   a;
		int   w;
		int   h;
		r = '0;
		case (cmd_e'(c.command))
			CMD_FILL: begin
				// oversized rectangles saturate, zero sizes touch nothing
				w = (int'(c.rect_width) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(c.rect_width);
				h = (int'(c.rect_height) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(c.rect_height);
				for (int row = 0; row < h; row++) begin
					for (int col = 0; col < w; col++) begin
						a = pix_addr(int'(c.pos_x) + col, int'(c.pos_y) + row, model_stride);
						if (a < FB_PIXELS_DEF) begin
							fb_model[a] = blend_px(fb_model[a], c.color);
						end else begin
							r.out_of_range = 1'b1;
						end
					end
				end
			end
			CMD_WRITE: begin
				a = pix_addr(int'(c.pos_x), int'(c.pos_y), model_stride);
				if (a < FB_PIXELS_DEF) begin
					fb_model[a] = c.color;
				end else begin
					r.out_of_range = 1'b1;
				end
			end
			CMD_READ: begin
				a = pix_addr(int'(c.pos_x), int'(c.pos_y), model_stride);
				if (a < FB_PIXELS_DEF) begin
					r.read_value = fb_model[a];
				end else begin
					r.out_of_range = 1'b1;
				end
			end
			default: begin
				// unused command: no effect, zero result
			end
		endcase
		return r;
	endfunction

	// sender gaps: mostly none or short, a few long, now and then a run with none at all
	function automatic int idle_gap();
		int p;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 3) begin
			burst_left = $urandom_range(8, 20);
			return 0;
		end
		if (p < 45)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// random color with fully transparent and fully opaque alpha favored
	function automatic logic [PIX_W-1:0] rand_color();
		logic [PIX_W-1:0] c;
		c = $urandom;
		case ($urandom_range(0, 7))
			0: c[31:24] = 8'h00;
			1: c[31:24] = 8'hFF;
			default: ;
		endcase
		return c;
	endfunction

	function automatic void queue_item(cmd_e op, int x, int y, int w, int h,
			logic [PIX_W-1:0] color);
		cmd_t c;
		int   a;
		c.command     = op;
		c.pos_x       = POS_W'(x);
		c.pos_y       = POS_W'(y);
		c.rect_width  = DIM_W'(w);
		c.rect_height = DIM_W'(h);
		c.color       = color;
		pending_cmds.push_back(c);
		if (op == CMD_WRITE) begin
			a = pix_addr(x, y, gen_stride);
			if (a < FB_PIXELS_DEF)
				gen_written[a] = 1'b1;
		end
	endfunction

	// unused rectangle fields of write and read still get random bits
	function automatic void queue_write(int x, int y, logic [PIX_W-1:0] color);
		queue_item(CMD_WRITE, x, y, $urandom_range(0, 127), $urandom_range(0, 127), color);
	endfunction

	// a read of a never written pixel is outside the contract, so write it first
	function automatic void queue_read(int x, int y);
		int a;
		a = pix_addr(x, y, gen_stride);
		if (a < FB_PIXELS_DEF && !gen_written[a])
			queue_write(x, y, rand_color());
		queue_item(CMD_READ, x, y, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
	endfunction

	// find a write position for an address under the current stride, if one exists
	function automatic bit write_pos(int a, output int x, output int y);
		x = 0;
		y = 0;
		for (int yy = 0; yy < 64; yy++) begin
			if (a >= yy * gen_stride && a - yy * gen_stride < 64) begin
				x = a - yy * gen_stride;
				y = yy;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// queue a fill, preceded by writes to every in-range pixel it would blend unwritten;
	// refused when more than max_writes writes are needed or a pixel cannot be written
	function automatic bit queue_fill(int x, int y, int w, int h, logic [PIX_W-1:0] color,
			int max_writes);
		bit need [FB_PIXELS_DEF];
		int n_need;
		int ew;
		int eh;
		int a;
		int wx;
		int wy;
		bit ok;
		need = '{default: 1'b0};
		n_need = 0;
		ok = 1'b1;
		ew = (w > MAX_DIM_DEF) ? MAX_DIM_DEF : w;
		eh = (h > MAX_DIM_DEF) ? MAX_DIM_DEF : h;
		for (int row = 0; row < eh; row++) begin
			for (int col = 0; col < ew; col++) begin
				a = pix_addr(x + col, y + row, gen_stride);
				if (a < FB_PIXELS_DEF && !gen_written[a] && !need[a]) begin
					need[a] = 1'b1;
					n_need++;
					if (!write_pos(a, wx, wy))
						ok = 1'b0;
				end
			end
		end
		if (n_need > max_writes)
			ok = 1'b0;
		if (ok) begin
			for (int i = 0; i < FB_PIXELS_DEF; i++) begin
				if (need[i]) begin
					void'(write_pos(i, wx, wy));
					queue_write(wx, wy, rand_color());
				end
			end
			queue_item(CMD_FILL, x, y, w, h, color);
		end
		return ok;
	endfunction

	// random commands with content reaching every path; big fills are rare
	function automatic void queue_random(int n_items);
		int  pick;
		int  w;
		int  h;
		bit  big;
		bit  ok;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				queue_write($urandom_range(0, 63), $urandom_range(0, 63), rand_color());
			end else if (pick < 60) begin
				queue_read($urandom_range(0, 63), $urandom_range(0, 63));
			end else if (pick < 95) begin
				big = ($urandom_range(0, 9) == 0);
				w = big ? $urandom_range(0, 127) : $urandom_range(0, 6);
				h = big ? $urandom_range(0, 127) : $urandom_range(0, 6);
				ok = queue_fill($urandom_range(0, 63), $urandom_range(0, 63), w, h,
					rand_color(), big ? 140 : 12);
				// fall back to small rectangles, then to an empty one
				for (int t = 0; t < 4 && !ok; t++) begin
					ok = queue_fill($urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(1, 4), $urandom_range(1, 4), rand_color(), 12);
				end
				if (!ok)
					queue_item(CMD_FILL, $urandom_range(0, 63), $urandom_range(0, 63), 0,
						$urandom_range(0, 127), $urandom);
			end else begin
				queue_item(CMD_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 127), $urandom_range(0, 127), $urandom);
			end
		end
	endfunction

	// driver: presents queued items, holds each until taken, and predicts on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (row_stride_we)
				model_stride = int'(row_stride_wdata);
			if (start && !busy)
				expected_results.push_back(apply_command(cmd));
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd <= pending_cmds.pop_front();
					start <= 1'b1;
					gap_left = idle_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobed result must match the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none, actual read_value %08h out_of_range %0b",
					$time, result.read_value, result.out_of_range);
			end else begin
				want = expected_results.pop_front();
				if (result.read_value !== want.read_value) begin
					err_count++;
					$display("%0t: read_value mismatch, expected %08h actual %08h",
						$time, want.read_value, result.read_value);
				end
				if (result.out_of_range !== want.out_of_range) begin
					err_count++;
					$display("%0t: out_of_range mismatch, expected %0b actual %0b",
						$time, want.out_of_range, result.out_of_range);
				end
			end
		end
	end

	// watchdog: too long with neither an item taken nor a result shown
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	// wait until every queued item is taken and answered, then let the block settle;
	// checked at the falling edge so that all rising edge updates have landed
	task automatic drain();
		@(negedge clk);
		while (!(pending_cmds.size() == 0 && !start && !busy && expected_results.size() == 0))
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	// stride changes only with the block idle
	task automatic set_stride(int value);
		drain();
		@(posedge clk);
		row_stride_we <= 1'b1;
		row_stride_wdata <= STRIDE_W'(value);
		@(posedge clk);
		row_stride_we <= 1'b0;
		gen_stride = value;
	endtask

	initial begin
		int strides [5];
		strides = '{127, 0, 1, 64, 0};
		strides[4] = $urandom_range(2, 63);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset stride of 64
		// first and last pixel of the store
		queue_write(0, 0, 32'hFFFF_FFFF);
		queue_read(0, 0);
		queue_write(63, 63, 32'h0000_0000);
		queue_read(63, 63);
		// transparent fill leaves the pixel, opaque fill replaces it
		void'(queue_fill(0, 0, 1, 1, 32'h00AB_CDEF, 0));
		queue_read(0, 0);
		void'(queue_fill(0, 0, 1, 1, 32'hFF12_3456, 0));
		queue_read(0, 0);
		// half alpha on a mid gray
		queue_write(5, 5, 32'h8080_8080);
		void'(queue_fill(5, 5, 1, 1, 32'h80FF_FFFF, 0));
		queue_read(5, 5);
		// oversized rectangle at the last pixel: one blend, the rest beyond the store
		void'(queue_fill(63, 63, 127, 127, 32'h7F89_ABCD, 0));
		queue_read(63, 63);
		// zero width, zero height
		queue_item(CMD_FILL, 0, 0, 0, 5, 32'hFFFF_FFFF);
		queue_item(CMD_FILL, 0, 0, 5, 0, 32'hFFFF_FFFF);
		// columns past the row end wrap into the next row
		void'(queue_fill(62, 10, 4, 2, 32'hC0F0_0F5A, 12));
		queue_read(1, 11);
		// unused command, fields all ones and all zeros
		queue_item(CMD_NOP, 63, 63, 127, 127, 32'hFFFF_FFFF);
		queue_item(CMD_NOP, 0, 0, 0, 0, 32'h0000_0000);

		queue_random(N_PHASE_ITEMS);

		// register extremes first: widest stride and zero stride, then stride 1, the reset stride 64 and a random one
		foreach (strides[i]) begin
			set_stride(strides[i]);
			queue_random(N_PHASE_ITEMS);
		end

		drain();
		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### sim.f
rtl/abrf_pkg.sv
rtl/abrf_ram.sv
rtl/abrf_addr.sv
rtl/abrf_blend.sv
rtl/alpha_blend_rect_fill.sv
bench/testbench.sv
